>>> rtl/edf_pkg.sv
// Package: shared constants, types and codes of the distance field block.
package edf_pkg;

    localparam int MaxWidth  = 64;
    localparam int MaxHeight = 64;
    localparam int Cells     = MaxWidth * MaxHeight;
    localparam int AddrW     = $clog2(Cells);
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int SizeW     = 7;
    localparam int DistW     = 15;
    localparam logic [DistW-1:0] DistTop = 15'h7fff;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPUTE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic {
        KIND_SUMMARY = 1'b0,
        KIND_CELL    = 1'b1
    } kind_t;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL,      // start scanning walls for one cell
        ST_WALL_RD,   // wall map read issued
        ST_WALL_CHK,  // compare squared distance
        ST_SQRT,      // serial root of best
        ST_STORE,     // write distance, update max
        ST_RD_WAIT,   // read distance word
        ST_DIV,       // serial texture division
        ST_DONE_CMP,
        ST_DONE_RD
    } state_t;

    // Control from sequencer to the shared root/divide unit.
    typedef struct packed {
        logic sqrt_start;
        logic div_start;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
    } unit_sts_t;

    function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                   input logic [SizeW-1:0] top);
        logic [SizeW-1:0] r;
        begin
            r = v;
            if (v == '0) r = SizeW'(1);
            else if (v > top) r = top;
            return r;
        end
    endfunction

endpackage

>>> rtl/euclidean_distance_field.sv
// Top level: brute force Euclidean distance field with APB size registers.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  command   | start, busy, command, cell_address,       | in
//            | wall_bit                                  |
//  result    | result_valid, result_kind, cell_distance, | out
//            | texture_byte, max_distance, no_walls      |
//  config    | psel penable pwrite paddr pwdata prdata   | in/out
//
// Load: writes the wall bit when the address lies inside the raster;
// no result. Read: a RAM read, then a 24-step serial divide.
// Compute: for every cell a sweep of all cells in use (a read state and
// a check state per wall-map word, one shared wall-map port), then a
// 15-step serial root; the summary is registered from the done state.
// busy stays high for the whole command; result_valid pulses one cycle
// and the receiver cannot stall it. Reset clears control and the
// max/wall-seen state; the RAMs are not cleared.
module euclidean_distance_field (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      command,
    input  logic [11:0]                     cell_address,
    input  logic                            wall_bit,
    output logic                            result_valid,
    output logic                            result_kind,
    output logic [14:0]                     cell_distance,
    output logic [7:0]                      texture_byte,
    output logic [14:0]                     max_distance,
    output logic                            no_walls,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    localparam int AW = edf_pkg::AddrW;
    localparam int CW = edf_pkg::ColW;
    localparam int RW = edf_pkg::RowW;
    localparam int DW = edf_pkg::DistW;
    localparam int SW = edf_pkg::SizeW;

    logic [SW-1:0] width_reg, height_reg;
    logic [SW-1:0] w_use, h_use;
    logic [AW:0]   count;

    assign pready = 1'b1;
    assign w_use  = edf_pkg::clamp_size(width_reg, SW'(edf_pkg::MaxWidth));
    assign h_use  = edf_pkg::clamp_size(height_reg, SW'(edf_pkg::MaxHeight));
    assign count  = (AW+1)'(w_use) * (AW+1)'(h_use);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SW'(64);
            height_reg <= SW'(64);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == 3'd0) width_reg <= pwdata[SW-1:0];
            else if (paddr == 3'd4) height_reg <= pwdata[SW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            edf_pkg::REG_WIDTH:  prdata = {25'd0, width_reg};
            edf_pkg::REG_HEIGHT: prdata = {25'd0, height_reg};
            default:             prdata = '0;
        endcase
    end

    // sequencer state
    edf_pkg::state_t st_reg, st_next;
    logic [CW-1:0] ci_reg, ci_next;   // cell column
    logic [RW-1:0] cj_reg, cj_next;   // cell row
    logic [AW-1:0] ca_reg, ca_next;   // cell address
    logic [CW-1:0] wi_reg, wi_next;   // scanned column
    logic [RW-1:0] wj_reg, wj_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic [12:0]   best_reg, best_next;
    logic          seen_reg, seen_next;       // wall found this pass
    logic [DW-1:0] top_reg, top_next;         // running max
    logic [DW-1:0] largest_reg, largest_next;
    logic          wseen_reg, wseen_next;
    logic [AW-1:0] raddr_reg, raddr_next;
    logic          rin_reg, rin_next;         // read address in range
    logic [DW-1:0] rd_reg, rd_next;
    // unit launched flags: first cycle of SQRT/DIV issues start
    logic          sqrt_run_reg, div_run_reg;

    // RAM ports
    logic          wm_we, wm_q, dm_we;
    logic [AW-1:0] wm_addr, dm_addr;
    logic [DW-1:0] dm_wdata, dm_q;
    logic [DW-1:0] code;

    edf_pkg::unit_ctl_t ctl;
    edf_pkg::unit_sts_t sts;
    logic [15:0] root;
    logic [7:0]  quot;

    logic accept;
    assign accept = start && (st_reg == edf_pkg::ST_IDLE);
    assign busy   = (st_reg != edf_pkg::ST_IDLE);

    edf_ram #(.WIDTH(1), .DEPTH(edf_pkg::Cells)) u_wall (
        .clk(clk), .we(wm_we), .addr(wm_addr), .wdata(wall_bit), .rdata(wm_q));
    edf_ram #(.WIDTH(DW), .DEPTH(edf_pkg::Cells)) u_dist (
        .clk(clk), .we(dm_we), .addr(dm_addr), .wdata(dm_wdata), .rdata(dm_q));
    edf_unit u_unit (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .radicand(best_reg),
        .dividend(rd_reg), .divisor(largest_reg), .sts(sts),
        .root(root), .quotient(quot));

    // squared distance of current pair
    logic [CW-1:0] dx;
    logic [RW-1:0] dy;
    logic [12:0]   sq;
    assign dx = (ci_reg > wi_reg) ? ci_reg - wi_reg : wi_reg - ci_reg;
    assign dy = (cj_reg > wj_reg) ? cj_reg - wj_reg : wj_reg - cj_reg;
    assign sq = 13'(dx * dx) + 13'(dy * dy);
    assign code = (root > 16'(edf_pkg::DistTop)) ? edf_pkg::DistTop : root[DW-1:0];

    logic last_wall, last_cell;
    assign last_wall = (wa_reg == AW'(count - 1));
    assign last_cell = (ca_reg == AW'(count - 1));

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            edf_pkg::ST_IDLE:
                if (start)
                begin
                    case (command)
                        edf_pkg::CMD_COMPUTE: st_next = edf_pkg::ST_CELL;
                        edf_pkg::CMD_READ:    st_next = edf_pkg::ST_RD_WAIT;
                        default:              st_next = edf_pkg::ST_IDLE;
                    endcase
                end
            edf_pkg::ST_CELL:     st_next = edf_pkg::ST_WALL_RD;
            edf_pkg::ST_WALL_RD:  st_next = edf_pkg::ST_WALL_CHK;
            edf_pkg::ST_WALL_CHK:
                if (last_wall) st_next = edf_pkg::ST_SQRT;
                else st_next = edf_pkg::ST_WALL_RD;
            edf_pkg::ST_SQRT:     if (!sts.busy && sqrt_run_reg)
                                      st_next = edf_pkg::ST_STORE;
            edf_pkg::ST_STORE:
                if (last_cell) st_next = edf_pkg::ST_DONE_CMP;
                else st_next = edf_pkg::ST_CELL;
            edf_pkg::ST_RD_WAIT:  st_next = edf_pkg::ST_DIV;
            edf_pkg::ST_DIV:      if (!sts.busy && div_run_reg) st_next = edf_pkg::ST_DONE_RD;
            edf_pkg::ST_DONE_CMP: st_next = edf_pkg::ST_IDLE;
            edf_pkg::ST_DONE_RD:  st_next = edf_pkg::ST_IDLE;
            default:              st_next = edf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqrt_run_reg <= 1'b0;
            div_run_reg  <= 1'b0;
        end
        else
        begin
            sqrt_run_reg <= (st_reg == edf_pkg::ST_SQRT);
            div_run_reg  <= (st_reg == edf_pkg::ST_DIV);
        end
    end

    // datapath and outputs
    always_comb
    begin
        ci_next = ci_reg; cj_next = cj_reg; ca_next = ca_reg;
        wi_next = wi_reg; wj_next = wj_reg; wa_next = wa_reg;
        best_next = best_reg; seen_next = seen_reg; top_next = top_reg;
        largest_next = largest_reg; wseen_next = wseen_reg;
        raddr_next = raddr_reg; rin_next = rin_reg; rd_next = rd_reg;
        wm_we = 1'b0; wm_addr = wa_reg;
        dm_we = 1'b0; dm_addr = raddr_reg; dm_wdata = code;
        ctl = '0;
        case (st_reg)
            edf_pkg::ST_IDLE:
            begin
                wm_addr = cell_address[AW-1:0];
                dm_addr = cell_address[AW-1:0];
                if (accept && command == edf_pkg::CMD_LOAD
                    && {1'b0, cell_address} < 13'(count))
                    wm_we = 1'b1;
                if (accept && command == edf_pkg::CMD_COMPUTE)
                begin
                    ci_next = '0; cj_next = '0; ca_next = '0;
                    top_next = '0; seen_next = 1'b0;
                end
                if (accept && command == edf_pkg::CMD_READ)
                begin
                    raddr_next = cell_address[AW-1:0];
                    rin_next = {1'b0, cell_address} < 13'(count);
                end
            end
            edf_pkg::ST_CELL:
            begin
                wi_next = '0; wj_next = '0; wa_next = '0;
                best_next = '1;
            end
            edf_pkg::ST_WALL_RD: wm_addr = wa_reg;
            edf_pkg::ST_WALL_CHK:
            begin
                if (wm_q)
                begin
                    seen_next = 1'b1;
                    if (sq < best_reg) best_next = sq;
                end
                wa_next = wa_reg + 1'b1;
                if (wi_reg == CW'(w_use - 1))
                begin
                    wi_next = '0;
                    wj_next = wj_reg + 1'b1;
                end
                else
                    wi_next = wi_reg + 1'b1;
            end
            edf_pkg::ST_SQRT:
                if (!sqrt_run_reg) ctl.sqrt_start = 1'b1;
            edf_pkg::ST_STORE:
            begin
                dm_addr = ca_reg;
                dm_we = 1'b1;
                dm_wdata = seen_reg ? code : edf_pkg::DistTop;
                if (dm_wdata > top_reg) top_next = dm_wdata;
                ca_next = ca_reg + 1'b1;
                if (ci_reg == CW'(w_use - 1))
                begin
                    ci_next = '0;
                    cj_next = cj_reg + 1'b1;
                end
                else
                    ci_next = ci_reg + 1'b1;
            end
            edf_pkg::ST_RD_WAIT:
                rd_next = rin_reg ? dm_q : '0;
            edf_pkg::ST_DIV:
                if (!div_run_reg) ctl.div_start = 1'b1;
            edf_pkg::ST_DONE_CMP:
            begin
                largest_next = top_reg;
                wseen_next = seen_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= edf_pkg::ST_IDLE;
            largest_reg <= '0;
            wseen_reg   <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            largest_reg <= largest_next;
            wseen_reg   <= wseen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ci_reg <= ci_next; cj_reg <= cj_next; ca_reg <= ca_next;
        wi_reg <= wi_next; wj_reg <= wj_next; wa_reg <= wa_next;
        best_reg <= best_next; seen_reg <= seen_next; top_reg <= top_next;
        raddr_reg <= raddr_next; rin_reg <= rin_next; rd_reg <= rd_next;
    end

    // result port; summary published with the new max
    logic summary;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            summary <= 1'b0;
        else
            summary <= (st_reg == edf_pkg::ST_DONE_CMP);
    end

    logic rd_done;
    assign rd_done = (st_reg == edf_pkg::ST_DONE_RD);
    assign result_valid  = summary || rd_done;
    assign result_kind   = rd_done ? edf_pkg::KIND_CELL : edf_pkg::KIND_SUMMARY;
    assign cell_distance = rd_done ? rd_reg : '0;
    assign texture_byte  = (rd_done && largest_reg != '0) ? quot : 8'd0;
    assign max_distance  = largest_reg;
    assign no_walls      = !wseen_reg;
endmodule

>>> rtl/edf_ram.sv
// Generic single port RAM with registered read.
module edf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> rtl/edf_unit.sv
// Shared bit-serial unit: square root of best<<16, or 255*d/max division.
module edf_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  edf_pkg::unit_ctl_t            ctl,
    input  logic [12:0]                   radicand,  // best squared distance
    input  logic [edf_pkg::DistW-1:0]     dividend,
    input  logic [edf_pkg::DistW-1:0]     divisor,
    output edf_pkg::unit_sts_t            sts,
    output logic [15:0]                   root,
    output logic [7:0]                    quotient
);
    // root of a 29-bit value held as 30 bits: 15 steps, 2 bits per step
    logic        mode_reg, mode_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [29:0] rem_reg, rem_next;
    logic [29:0] val_reg, val_next;
    logic [15:0] acc_reg, acc_next;
    logic [29:0] trial;
    logic [23:0] dnum;
    logic [23:0] dvs;

    assign dvs  = {9'd0, divisor};
    assign dnum = {9'd0, dividend} * 24'd255;

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        val_next  = val_reg;
        acc_next  = acc_reg;
        trial     = '0;
        if (ctl.sqrt_start)
        begin
            mode_next = 1'b0;
            cnt_next  = 5'd15;
            rem_next  = '0;
            val_next  = {1'b0, radicand, 16'd0};
            acc_next  = '0;
        end
        else if (ctl.div_start)
        begin
            mode_next = 1'b1;
            cnt_next  = 5'd24;
            rem_next  = '0;
            val_next  = {6'd0, dnum};
            acc_next  = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 5'd1;
            if (!mode_reg)
            begin
                rem_next = {rem_reg[27:0], val_reg[29:28]};
                val_next = {val_reg[27:0], 2'b00};
                trial    = {12'd0, acc_reg, 2'b01};
                if (rem_next >= trial)
                begin
                    rem_next = rem_next - trial;
                    acc_next = {acc_reg[14:0], 1'b1};
                end
                else
                    acc_next = {acc_reg[14:0], 1'b0};
            end
            else
            begin
                rem_next = {rem_reg[28:0], val_reg[23]};
                val_next = {val_reg[28:0], 1'b0};
                if (rem_next >= {6'd0, dvs})
                begin
                    rem_next = rem_next - {6'd0, dvs};
                    acc_next = {acc_reg[14:0], 1'b1};
                end
                else
                    acc_next = {acc_reg[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        val_reg <= val_next;
        acc_reg <= acc_next;
    end

    assign sts.busy = (cnt_reg != '0);
    assign root     = acc_reg;
    // distance at or above the max saturates to 255; below it the quotient fits 8 bits
    assign quotient = (dividend >= divisor) ? 8'd255 : acc_reg[7:0];

    busy_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ((cnt_reg != '0) && !ctl.sqrt_start && !ctl.div_start)
        |=> cnt_reg == $past(cnt_reg) - 5'd1)
        else $error("unit counter skipped");
    start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sqrt_start |=> cnt_reg == 5'd15)
        else $error("root start did not load counter");
    div_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.div_start && !ctl.sqrt_start) |=> cnt_reg == 5'd24)
        else $error("divide start did not load counter");
endmodule

>>> bench/edf_checker.sv
// Checker: predicts distance field answers and compares them with the result port.
`timescale 1ns / 1ps

module edf_checker
    import edf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  command,
    input  logic [11:0] cell_address,
    input  logic        wall_bit,
    input  logic        result_valid,
    input  logic        result_kind,
    input  logic [14:0] cell_distance,
    input  logic [7:0]  texture_byte,
    input  logic [14:0] max_distance,
    input  logic        no_walls,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic        kind;
        logic [14:0] cdist;
        logic [7:0]  tex;
        logic [14:0] maxd;
        logic        nowall;
    } answer_t;

    logic              wall_img [Cells];
    logic [DistW-1:0]  dist_img [Cells];
    logic [DistW-1:0]  top_dist;
    logic              any_wall;
    logic [SizeW-1:0]  cols_reg;
    logic [SizeW-1:0]  rows_reg;
    answer_t           answers_due [$];

    // integer root, bit by bit from the top pair
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        end
    endfunction

    function automatic int eff_size(input logic [SizeW-1:0] v, input int top);
        begin
            if (v == 0) return 1;
            if (v > top) return top;
            return v;
        end
    endfunction

    task automatic build_field();
        int w, h, n, dx, dy;
        int wc [$];
        int wr [$];
        longint unsigned best, sq, q;
        logic [DistW-1:0] code, hi;
        begin
            w  = eff_size(cols_reg, MaxWidth);
            h  = eff_size(rows_reg, MaxHeight);
            hi = '0;
            for (int j = 0; j < h; j++)
                for (int i = 0; i < w; i++)
                    if (wall_img[i + j * w])
                    begin
                        wc.push_back(i);
                        wr.push_back(j);
                    end
            n = wc.size();
            for (int j = 0; j < h; j++)
                for (int i = 0; i < w; i++)
                begin
                    code = DistTop;
                    if (n != 0)
                    begin
                        best = '1;
                        for (int k = 0; k < n; k++)
                        begin
                            dx = i - wc[k];
                            dy = j - wr[k];
                            sq = dx * dx + dy * dy;
                            if (sq < best) best = sq;
                        end
                        q = root_floor(best << 16);
                        code = (q > DistTop) ? DistTop : q[DistW-1:0];
                    end
                    dist_img[i + j * w] = code;
                    if (code > hi) hi = code;
                end
            top_dist = hi;
            any_wall = (n != 0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_dist = '0;
            any_wall = 1'b0;
            cols_reg = SizeW'(MaxWidth);
            rows_reg = SizeW'(MaxHeight);
            errors   = 0;
            answers_due.delete();
        end
        else
        begin
            int      cnt;
            answer_t a, got;
            cnt = eff_size(cols_reg, MaxWidth) * eff_size(rows_reg, MaxHeight);
            // result first: it belongs to a command taken earlier
            if (result_valid)
            begin
                got = {result_kind, cell_distance, texture_byte, max_distance, no_walls};
                if (answers_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, got);
                end
                else
                begin
                    a = answers_due.pop_front();
                    if (got.kind !== a.kind)
                    begin
                        errors++;
                        $display("%0t: result_kind exp %0d got %0d", $time, a.kind, got.kind);
                    end
                    if (got.cdist !== a.cdist)
                    begin
                        errors++;
                        $display("%0t: cell_distance exp %0d got %0d",
                                 $time, a.cdist, got.cdist);
                    end
                    if (got.tex !== a.tex)
                    begin
                        errors++;
                        $display("%0t: texture_byte exp %0d got %0d", $time, a.tex, got.tex);
                    end
                    if (got.maxd !== a.maxd)
                    begin
                        errors++;
                        $display("%0t: max_distance exp %0d got %0d",
                                 $time, a.maxd, got.maxd);
                    end
                    if (got.nowall !== a.nowall)
                    begin
                        errors++;
                        $display("%0t: no_walls exp %0d got %0d", $time, a.nowall, got.nowall);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_WIDTH) cols_reg = pwdata[SizeW-1:0];
                else                       rows_reg = pwdata[SizeW-1:0];
            end
            if (start && !busy)
            begin
                a = '0;
                case (cmd_t'(command))
                    CMD_LOAD:
                        if (cell_address < cnt) wall_img[cell_address] = wall_bit;
                    CMD_COMPUTE:
                    begin
                        build_field();
                        a.kind   = KIND_SUMMARY;
                        a.maxd   = top_dist;
                        a.nowall = !any_wall;
                        answers_due.push_back(a);
                    end
                    CMD_READ:
                    begin
                        a.kind = KIND_CELL;
                        if (cell_address < cnt)
                        begin
                            a.cdist = dist_img[cell_address];
                            if (top_dist != 0)
                                a.tex = ((255 * a.cdist) / top_dist > 255) ? 8'd255
                                        : 8'((255 * a.cdist) / top_dist);
                        end
                        a.maxd   = top_dist;
                        a.nowall = !any_wall;
                        answers_due.push_back(a);
                    end
                    default: ;
                endcase
            end
        end
        pending = answers_due.size();
    end

endmodule

>>> bench/tb_euclidean_distance_field.sv
// Testbench top: command stimulus, size register writes and verdict.
`timescale 1ns / 1ps

module tb_euclidean_distance_field;
    import edf_pkg::*;

    localparam int IdleLimit = 200000;  // cycles with no word moving

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [11:0] cell_address;
    logic        wall_bit;
    logic        result_valid;
    logic        result_kind;
    logic [14:0] cell_distance;
    logic [7:0]  texture_byte;
    logic [14:0] max_distance;
    logic        no_walls;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          idle_cycles;

    // stimulus-side bookkeeping: which distances exist
    bit          dist_known [Cells];
    int          grid_w;
    int          grid_h;
    int          gap_pct;
    int          sent;

    euclidean_distance_field i_dut (.*);

    edf_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // watchdog: any accepted command or result word resets the count
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("tb_euclidean_distance_field: FAIL");
            $finish;
        end
    end

    // one command word; the start line stays high into the next word if no gap
    task automatic send(input cmd_t cmd, input int addr, input logic wbit);
        int gap;
        begin
            gap = 0;
            if ($urandom_range(99) < gap_pct) gap = $urandom_range(1, 4);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start        <= 1'b1;
            command      <= cmd;
            cell_address <= addr[11:0];
            wall_bit     <= wbit;
            @(posedge clk);
            while (busy) @(posedge clk);
            sent++;
            if (cmd == CMD_COMPUTE)
                for (int k = 0; k < grid_w * grid_h; k++) dist_known[k] = 1'b1;
        end
    endtask

    // let the block drain: wait until no answer is pending and the block is idle
    task automatic drain();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending != 0 || busy) @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input int value);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
    endtask

    task automatic set_grid(input int w, input int h);
        begin
            drain();
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
            grid_w = (w == 0) ? 1 : (w > MaxWidth) ? MaxWidth : w;
            grid_h = (h == 0) ? 1 : (h > MaxHeight) ? MaxHeight : h;
        end
    endtask

    task automatic load_all(input int wall_pct);
        begin
            for (int k = 0; k < grid_w * grid_h; k++)
                send(CMD_LOAD, k, $urandom_range(99) < wall_pct);
        end
    endtask

    // a read of a cell whose distance exists, or else of a cell outside the raster when it is not full
    task automatic read_some();
        int a;
        begin
            a = $urandom_range(grid_w * grid_h - 1);
            if (dist_known[a] && $urandom_range(3) != 0)
                send(CMD_READ, a, 1'($urandom_range(1)));
            else if (grid_w * grid_h < Cells)
                send(CMD_READ, $urandom_range(grid_w * grid_h, Cells - 1),
                     1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        int w, h, pct, round;
        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_LOAD;
        cell_address = '0;
        wall_bit     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        gap_pct      = 0;
        sent         = 0;
        grid_w       = MaxWidth;
        grid_h       = MaxHeight;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: read before any compute, unused command, tiny grids
        set_grid(2, 2);
        send(CMD_READ, Cells - 1, 1'b1);
        send(CMD_NONE, 12'h5a5, 1'b1);
        load_all(0);
        send(CMD_LOAD, Cells - 1, 1'b1);     // outside raster, dropped
        send(CMD_COMPUTE, 0, 1'b0);          // no walls at all
        send(CMD_READ, 0, 1'b0);
        send(CMD_READ, 3, 1'b0);
        send(CMD_LOAD, 3, 1'b1);
        send(CMD_COMPUTE, 0, 1'b0);
        send(CMD_READ, 0, 1'b0);
        send(CMD_READ, 1, 1'b0);
        send(CMD_READ, 3, 1'b0);
        load_all(100);                       // every cell a wall
        send(CMD_COMPUTE, 0, 1'b0);
        send(CMD_READ, 2, 1'b0);
        send(CMD_READ, 4, 1'b0);
        set_grid(0, 0);                      // zero acts as one
        send(CMD_LOAD, 0, 1'b1);
        send(CMD_COMPUTE, 0, 1'b0);
        send(CMD_READ, 0, 1'b0);
        send(CMD_READ, 1, 1'b0);

        // random rounds: fresh raster, compute, then mixed traffic
        round = 0;
        while (sent < 600)
        begin
            case (round % 3)
                0: gap_pct = 0;
                1: gap_pct = 58;
                default: gap_pct = 11;
            endcase
            case ($urandom_range(5))
                0: begin w = 127; h = 1; end
                1: begin w = 1;   h = 64; end
                2: begin w = 64;  h = 0; end
                default:
                begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 8);
                end
            endcase
            set_grid(w, h);
            case ($urandom_range(3))
                0: pct = 0;
                1: pct = 5;
                2: pct = 100;
                default: pct = 40;
            endcase
            load_all(pct);
            send(CMD_COMPUTE, $urandom_range(Cells - 1), 1'($urandom_range(1)));
            for (int n = 0; n < 20; n++)
            begin
                case ($urandom_range(9))
                    0: send(CMD_LOAD, $urandom_range(grid_w * grid_h - 1),
                            1'($urandom_range(1)));
                    1: send(CMD_LOAD, $urandom_range(Cells - 1), 1'($urandom_range(1)));
                    2: send(CMD_NONE, $urandom_range(Cells - 1), 1'($urandom_range(1)));
                    default: read_some();
                endcase
            end
            if ($urandom_range(1))
            begin
                send(CMD_COMPUTE, 0, 1'b0);
                read_some();
            end
            // full-size raster now and then: loads anywhere, reads of old distances
            if (round % 5 == 4)
            begin
                set_grid(64, 64);
                for (int n = 0; n < 30; n++)
                begin
                    if ($urandom_range(1))
                        send(CMD_LOAD, $urandom_range(Cells - 1), 1'($urandom_range(1)));
                    else
                        read_some();
                end
            end
            round++;
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb_euclidean_distance_field: PASS");
        else
            $display("tb_euclidean_distance_field: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/edf_pkg.sv
rtl/edf_ram.sv
rtl/edf_unit.sv
rtl/euclidean_distance_field.sv
bench/edf_checker.sv
bench/tb_euclidean_distance_field.sv
